// ----- design/kpc_pkg.sv -----
// Shared types, codes and a helper function for the k-mer pattern counter.
package kpc_pkg;

  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 4'd4;
  localparam int RUN_BITS = 4;
  localparam int INDEX_BITS = 16;
  localparam int VALUE_BITS = 32;

  typedef enum logic [1:0] {
    MODE_BASE         = 2'd0,
    MODE_READ_PATTERN = 2'd1,
    MODE_READ_BASE    = 2'd2,
    MODE_NEW_SEQ      = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [7:0]            base_char;
    logic [INDEX_BITS-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] count_value;
    logic                  from_histogram;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] code;
  } base_t;

  // Request from the sequence front end to the pattern count store.
  typedef struct packed {
    logic issue;
    logic bump;
  } store_req_t;

  // Maps a sequence character to its 2-bit base: t, c, a, g in either case.
  function automatic base_t base_code(input logic [7:0] ch);
    base_t b;
    b.hit  = 1'b1;
    b.code = 2'd0;
    case (ch) inside
      "t", "T": b.code = 2'd0;
      "c", "C": b.code = 2'd1;
      "a", "A": b.code = 2'd2;
      "g", "G": b.code = 2'd3;
      default:  b.hit  = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ----- design/kpc_count_store.sv -----
// Pattern count memory with clearing pass, saturating read-modify-write and forwarding.
module kpc_count_store #(
  parameter int ADDR_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kpc_pkg::store_req_t    req,
  input  logic [ADDR_BITS-1:0]   addr,
  output logic                   busy,
  output logic [COUNT_BITS-1:0]  rd_value
);
  import kpc_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic [ADDR_BITS-1:0]  s1_addr;
  logic                  s1_bump;
  logic                  clearing;
  logic [ADDR_BITS-1:0]  clear_addr;
  logic                  wb_valid;
  logic [ADDR_BITS-1:0]  wb_addr;
  logic [COUNT_BITS-1:0] wb_data;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] bumped;

  // The write issued at the same edge as this word's read is not yet in rdata.
  assign rd_value = (wb_valid && wb_addr == s1_addr) ? wb_data : rdata;
  assign bumped   = (&rd_value) ? rd_value : rd_value + COUNT_BITS'(1);
  assign busy     = clearing;

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clear_addr;
      wr_data = '0;
    end else begin
      wr_en   = s1_bump;
      wr_addr = s1_addr;
      wr_data = bumped;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.issue) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.issue) begin
      s1_addr <= addr;
    end
    if (wr_en) begin
      wb_addr <= wr_addr;
      wb_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
      s1_bump    <= 1'b0;
      wb_valid   <= 1'b0;
    end else begin
      s1_bump <= req.issue & req.bump;
      if (wr_en) begin
        wb_valid <= 1'b1;
      end
      if (clearing) begin
        clear_addr <= clear_addr + ADDR_BITS'(1);
        if (&clear_addr) begin
          clearing <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/kpc_seq_front.sv -----
// Sequence front end: base decoding, pattern shift, good run and base totals.
module kpc_seq_front #(
  parameter int MAX_WINDOW = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  kpc_pkg::item_t                item,
  input  logic [kpc_pkg::CFG_BITS-1:0]  window_size,
  output kpc_pkg::store_req_t           req,
  output logic [2*MAX_WINDOW-1:0]       pat_addr,
  output logic [COUNT_BITS-1:0]         base_value
);
  import kpc_pkg::*;

  localparam int ADDR_BITS = 2 * MAX_WINDOW;

  logic [ADDR_BITS-1:0]  pattern_shift;
  logic [ADDR_BITS-1:0]  pattern_shift_next;
  logic [RUN_BITS-1:0]   good_run;
  logic [RUN_BITS-1:0]   good_run_next;
  logic [RUN_BITS-1:0]   run_inc;
  logic [COUNT_BITS-1:0] base_totals [4];
  logic [CFG_BITS-1:0]   win;
  logic [ADDR_BITS-1:0]  mask;
  logic [ADDR_BITS+1:0]  shifted;
  base_t                 b;
  logic [1:0]            base_sel;
  logic                  base_inc;

  assign b = base_code(item.base_char);

  always_comb begin
    win = window_size;
    if (win == '0) begin
      win = CFG_BITS'(1);
    end
    if (win > CFG_BITS'(MAX_WINDOW)) begin
      win = CFG_BITS'(MAX_WINDOW);
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      mask[i] = (i < 2 * int'(win));
    end
  end

  assign shifted  = {pattern_shift, b.code};
  assign run_inc  = (&good_run) ? good_run : good_run + RUN_BITS'(1);
  assign base_sel = (item.mode == MODE_BASE) ? b.code : item.read_index[1:0];
  assign base_value = base_totals[base_sel];

  always_comb begin
    pattern_shift_next = pattern_shift;
    good_run_next      = good_run;
    base_inc           = 1'b0;
    req                = '0;
    pat_addr           = ADDR_BITS'(item.read_index);
    unique case (item.mode)
      MODE_BASE: begin
        if (b.hit) begin
          base_inc           = 1'b1;
          pattern_shift_next = shifted[ADDR_BITS-1:0] & mask;
          good_run_next      = run_inc;
          pat_addr           = pattern_shift_next;
          req.issue          = (run_inc >= win);
          req.bump           = (run_inc >= win);
        end else begin
          good_run_next = '0;
        end
      end
      MODE_READ_PATTERN: begin
        req.issue = 1'b1;
      end
      MODE_READ_BASE: begin
      end
      MODE_NEW_SEQ: begin
        pattern_shift_next = '0;
        good_run_next      = '0;
      end
      default: begin
      end
    endcase
    req.issue = req.issue & accept;
    req.bump  = req.bump & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_shift <= '0;
      good_run      <= '0;
      for (int i = 0; i < 4; i++) begin
        base_totals[i] <= '0;
      end
    end else if (accept) begin
      pattern_shift <= pattern_shift_next;
      good_run      <= good_run_next;
      if (base_inc && !(&base_value)) begin
        base_totals[base_sel] <= base_value + COUNT_BITS'(1);
      end
    end
  end

endmodule

// ----- design/kmer_pattern_counter_unit.sv -----
// A read word is held in the s1 stage registers and then registered into result; s1 holds it while result stalls.
// Throughput: one word per cycle while the store is not clearing and the result stage is not stalled.
// A pattern update reads at acceptance and writes back in the following cycle, forwarded to the next read.
// Reset: control state clears, then a pass over all 4**MAX_WINDOW entries (65536 by default) zeroes
// the pattern store while no word is taken; configuration writes are taken throughout.
module kmer_pattern_counter_unit #(
  parameter int MAX_WINDOW = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  kpc_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output kpc_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpc_pkg::CFG_BITS-1:0]  cfg_data
);
  import kpc_pkg::*;

  localparam int ADDR_BITS = 2 * MAX_WINDOW;

  logic                  accept;
  logic [CFG_BITS-1:0]   window_size;
  store_req_t            req;
  logic [ADDR_BITS-1:0]  pat_addr;
  logic [COUNT_BITS-1:0] base_value;
  logic                  busy;
  logic [COUNT_BITS-1:0] rd_value;
  logic                  s1_valid;
  logic                  s1_read;
  logic                  s1_hist;
  logic [COUNT_BITS-1:0] s1_base_value;
  logic                  s1_adv;
  logic [COUNT_BITS-1:0] s1_count;
  logic [63:0]           count_wide;
  result_t               s1_result;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = !(s1_valid && s1_read && result_valid && !result_ready);
  assign item_ready = !busy && s1_adv;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window_size <= cfg_data;
    end
  end

  kpc_seq_front #(
    .MAX_WINDOW(MAX_WINDOW),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .window_size(window_size),
    .req        (req),
    .pat_addr   (pat_addr),
    .base_value (base_value)
  );

  kpc_count_store #(
    .ADDR_BITS (ADDR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .addr    (pat_addr),
    .busy    (busy),
    .rd_value(rd_value)
  );

  // Counts wider than the result field are shown as all ones.
  assign s1_count   = s1_hist ? s1_base_value : rd_value;
  assign count_wide = 64'(s1_count);
  always_comb begin
    s1_result.from_histogram = s1_hist;
    if (count_wide > 64'h0000_0000_FFFF_FFFF) begin
      s1_result.count_value = '1;
    end else begin
      s1_result.count_value = count_wide[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hist       <= (item.mode == MODE_READ_BASE);
      s1_base_value <= base_value;
    end
    if (s1_valid && s1_read && s1_adv) begin
      result <= s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s1_read      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_read  <= (item.mode == MODE_READ_PATTERN) || (item.mode == MODE_READ_BASE);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_read && s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sim/tb_kmer_pattern_counter_unit.sv -----
// Testbench for the k-mer pattern counter: a directed table, then random phases over windows.
module tb_kmer_pattern_counter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kpc_pkg::*;

  localparam int     SETTLE_CYCLES = 6;
  localparam int     NUM_PHASES    = 12;
  localparam int     PHASE_ITEMS   = 136;
  localparam int     WINDOW_CAP    = 8;
  localparam int     MAX_REPORTS   = 10;
  localparam int     SEEN_DEPTH    = 64;
  localparam longint CYCLE_LIMIT   = 600000;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_BLOCKS
  } stall_style_t;

  typedef struct {
    item_t   stim;
    logic    typed;
    result_t want;
  } row_t;

  localparam logic [7:0] BASE_LETTERS [8] = '{"t", "c", "a", "g", "T", "C", "A", "G"};
  localparam logic [3:0] PHASE_WINDOWS [NUM_PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6, 4'd2, 4'd5, 4'd7, 4'd9, 4'd4, 4'd1};

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  item_t               item         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data     = '0;

  // Predicted state of the counter.
  logic [3:0]  window_reg = WINDOW_RESET;
  logic [15:0] shift_reg  = '0;
  logic [3:0]  run_len    = '0;
  bit   [31:0] pattern_tally [0:65535];
  bit   [31:0] base_tally [0:3];
  logic [15:0] seen_patterns [$];

  result_t      count_replies [$];
  row_t         directed_rows [$];
  int           mismatches  = 0;
  int           burst_left  = 0;
  longint       cycle_count = 0;
  logic [5:0]   stall_phase = '0;
  stall_style_t stall_style = READY_ALWAYS;

  kmer_pattern_counter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bit 2 flags a recognised base; bits 1:0 hold its code.
  function automatic logic [2:0] decode_base(input logic [7:0] ch);
    case (ch)
      "t", "T": return 3'b100;
      "c", "C": return 3'b101;
      "a", "A": return 3'b110;
      "g", "G": return 3'b111;
      default:  return 3'b000;
    endcase
  endfunction

  function automatic row_t mk_row(input mode_t m, input logic [7:0] ch, input logic [15:0] idx,
                                  input logic typed, input logic [31:0] count,
                                  input logic hist);
    row_t r;
    r.stim.mode                = m;
    r.stim.base_char           = ch;
    r.stim.read_index          = idx;
    r.typed                    = typed;
    r.want.count_value         = count;
    r.want.from_histogram      = hist;
    return r;
  endfunction

  task automatic advance_tally(input item_t it, output logic gives, output result_t r);
    logic [2:0]  b;
    int unsigned w;
    logic [15:0] mask;
    gives = 1'b0;
    r     = '0;
    case (it.mode)
      MODE_BASE: begin
        b = decode_base(it.base_char);
        if (!b[2]) begin
          run_len = '0;
        end else begin
          w = (window_reg == 4'd0) ? 1 : ((window_reg > WINDOW_CAP) ? WINDOW_CAP : window_reg);
          mask = 16'((32'd1 << (2 * w)) - 32'd1);
          if (base_tally[b[1:0]] != '1) base_tally[b[1:0]] = base_tally[b[1:0]] + 1;
          shift_reg = {shift_reg[13:0], b[1:0]} & mask;
          if (run_len != 4'hF) run_len = run_len + 1'b1;
          if (run_len >= w) begin
            if (pattern_tally[shift_reg] != '1)
              pattern_tally[shift_reg] = pattern_tally[shift_reg] + 1;
            seen_patterns.push_back(shift_reg);
            if (seen_patterns.size() > SEEN_DEPTH) void'(seen_patterns.pop_front());
          end
        end
      end
      MODE_NEW_SEQ: begin
        shift_reg = '0;
        run_len   = '0;
      end
      MODE_READ_PATTERN: begin
        gives            = 1'b1;
        r.count_value    = pattern_tally[it.read_index];
        r.from_histogram = 1'b0;
      end
      default: begin
        gives            = 1'b1;
        r.count_value    = base_tally[it.read_index[1:0]];
        r.from_histogram = 1'b1;
      end
    endcase
  endtask

  // The sender works in bursts; this task only lowers valid at the start of a gap.
  task automatic send_item(input item_t it, input logic typed, input result_t typed_want);
    logic    gives;
    result_t want;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    advance_tally(it, gives, want);
    if (gives) count_replies.push_back(typed ? typed_want : want);
  endtask

  // Written only once every read has been answered and the pipeline has drained.
  task automatic write_window(input logic [3:0] w);
    item_valid <= 1'b0;
    while (count_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_reg = w;
  endtask

  task automatic report_mismatch(input string what, input result_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected count %0d hist %0b, got count %0d hist %0b", $time, what,
               want.count_value, want.from_histogram, result.count_value,
               result.from_histogram);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (count_replies.size() == 0) begin
        report_mismatch("unexpected word", '0);
      end else begin
        want = count_replies.pop_front();
        if (result.count_value !== want.count_value ||
            result.from_histogram !== want.from_histogram)
          report_mismatch("mismatch", want);
      end
    end
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '1) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      READY_ALWAYS: result_ready <= 1'b1;
      READY_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: result_ready <= (stall_phase[1:0] == 2'b00);
      default:      result_ready <= stall_phase[3];
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** kmer_pattern_counter_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    item_t it;
    int    roll;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset window of four; the first reads see the cleared stores.
    directed_rows.push_back(mk_row(MODE_READ_PATTERN, 8'h00, 16'h0000, 1'b1, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_READ_BASE,    8'hFF, 16'hFFFF, 1'b1, 32'd0, 1'b1));
    directed_rows.push_back(mk_row(MODE_BASE,         "t",   16'hFFFF, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "C",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "a",   16'h5555, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "G",   16'hAAAA, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_READ_PATTERN, 8'h00, 16'h001B, 1'b1, 32'd1, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "T",   16'h0000, 1'b0, 32'd0, 1'b0));
    // An unknown character breaks the run but keeps the shifted index.
    directed_rows.push_back(mk_row(MODE_BASE,         "x",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "g",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_READ_PATTERN, 8'hFF, 16'h006C, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_NEW_SEQ,      8'hFF, 16'hFFFF, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "A",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "A",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "A",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         "A",   16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_READ_PATTERN, 8'h00, 16'h00AA, 1'b0, 32'd0, 1'b0));
    // Only the low two bits select a base total.
    directed_rows.push_back(mk_row(MODE_READ_BASE,    8'h00, 16'hFFFE, 1'b0, 32'd0, 1'b1));
    directed_rows.push_back(mk_row(MODE_BASE,         8'h00, 16'h0000, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_BASE,         8'hFF, 16'hFFFF, 1'b0, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_READ_BASE,    8'h00, 16'h0001, 1'b0, 32'd0, 1'b1));
    directed_rows.push_back(mk_row(MODE_READ_BASE,    8'h00, 16'h0003, 1'b0, 32'd0, 1'b1));
    directed_rows.push_back(mk_row(MODE_READ_PATTERN, 8'h00, 16'hFFFF, 1'b1, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(MODE_NEW_SEQ,      8'h00, 16'h0000, 1'b0, 32'd0, 1'b0));
    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    // The run is deliberately left open across a window change.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_window(PHASE_WINDOWS[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll          = $urandom_range(0, 99);
        it.base_char  = 8'($urandom);
        it.read_index = 16'($urandom);
        if (roll < 66) begin
          it.mode      = MODE_BASE;
          it.base_char = BASE_LETTERS[$urandom_range(0, 7)];
        end else if (roll < 72) begin
          it.mode = MODE_BASE;
        end else if (roll < 76) begin
          it.mode = MODE_NEW_SEQ;
        end else if (roll < 88) begin
          it.mode = MODE_READ_PATTERN;
          case ($urandom_range(0, 3))
            0, 1: it.read_index = shift_reg;
            2: begin
              if (seen_patterns.size() != 0)
                it.read_index = seen_patterns[$urandom_range(0, seen_patterns.size() - 1)];
            end
            default: ;
          endcase
        end else begin
          it.mode = MODE_READ_BASE;
        end
        send_item(it, 1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    while (count_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && count_replies.size() == 0) begin
      $display("** kmer_pattern_counter_unit: PASSED **");
    end else begin
      $display("** kmer_pattern_counter_unit: FAILED **");
    end
    $finish;
  end

endmodule
